>>> hw/rtl/vdi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vdi_pkg;

   // Field widths fixed by the channel format
   localparam int FIELD_W = 32;
   localparam int UIDX_W  = 10;

   // Defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int COORD_BITS_DEF  = 32;

   // Compare chain: entry i lives in cell i % NUM_CELLS, row i / NUM_CELLS
   localparam int CELL_BITS = 4;
   localparam int NUM_CELLS = 1 << CELL_BITS;

   typedef struct packed {
      logic signed [FIELD_W-1:0] coord_x;
      logic signed [FIELD_W-1:0] coord_y;
      logic signed [FIELD_W-1:0] coord_z;
      logic                      last_vertex;
   } req_type;

   typedef struct packed {
      logic [UIDX_W-1:0] unique_index;
      logic              is_new;
      logic              table_full;
   } rsp_type;

   // Control part of a probe token walking down the cell chain
   typedef struct packed {
      logic valid;
      logic last;
      logic found;
   } tok_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/vdi_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module vdi_cell #(
   parameter int CELL_ID = 0,
   parameter int ROW_W   = 6,
   parameter int IDX_W   = 10,
   parameter int CNT_W   = 11,
   parameter int KEY_W   = 96,
   parameter int SLICE   = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  vdi_pkg::tok_type tok_i,
   input  logic [ROW_W-1:0] row_i,
   input  logic [IDX_W-1:0] idx_i,
   output vdi_pkg::tok_type tok_o,
   output logic [ROW_W-1:0] row_o,
   output logic [IDX_W-1:0] idx_o,
   input  logic [KEY_W-1:0] key_i,
   input  logic [CNT_W-1:0] count_i,
   input  logic             wr_en_i,
   input  logic [ROW_W-1:0] wr_row_i,
   input  logic [KEY_W-1:0] wr_key_i
);
   import vdi_pkg::*;

   localparam int G_W = ROW_W + CELL_BITS + CNT_W;
   localparam logic [CELL_BITS-1:0] ID = CELL_BITS'(CELL_ID);

   logic [KEY_W-1:0] mem_ff [SLICE];
   logic [KEY_W-1:0] rd_ff;
   tok_type          tok_ff;
   logic [ROW_W-1:0] row_ff;
   logic [IDX_W-1:0] idx_ff;

   logic [G_W-1:0]   g_ext;
   logic [G_W-1:0]   cnt_ext;
   logic             hit;

   // local slice of the vertex store
   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         mem_ff[wr_row_i] <= wr_key_i;
      end
      rd_ff <= mem_ff[row_i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_i;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_i;
      idx_ff <= idx_i;
   end

   // entry index = row * NUM_CELLS + cell; live only below the fill count
   assign g_ext   = G_W'({row_ff, ID});
   assign cnt_ext = G_W'(count_i);
   assign hit     = tok_ff.valid && (g_ext < cnt_ext) && (rd_ff == key_i);

   always_comb begin
      tok_o       = tok_ff;
      tok_o.found = tok_ff.found | hit;
   end

   assign row_o = row_ff;
   assign idx_o = hit ? g_ext[IDX_W-1:0] : idx_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vertex_dedup_indexer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                             Moves
// req       in   req_valid req_stall req_data      one vertex (x, y, z, last mark)
// rsp       out  rsp_valid rsp_stall rsp_data      index, is-new, table-full
//
// One vertex at a time: a req transfer starts a probe that feeds one store
// row a cycle into a chain of NUM_CELLS compare cells, one cell a cycle.
// The time per vertex is set by the row scan of ceil(count / NUM_CELLS)
// rows (at least 1) plus the chain length, count being the entries in use.
// Synchronous reset clears the state, fill count, result valid and chain tokens; the store is not swept.
// rsp is registered; a waiting result blocks only the final commit step.

module vertex_dedup_indexer_core #(
   parameter int TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = vdi_pkg::COORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vdi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vdi_pkg::rsp_type rsp_data
);
   import vdi_pkg::*;

   localparam int STORE_BITS = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
   localparam int KEY_W      = 3 * STORE_BITS;
   localparam int SLICE      = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
   localparam int ROW_W      = (SLICE > 1) ? $clog2(SLICE) : 1;
   localparam int IDX_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);

   // sequencer state
   state_type        state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             last_ff, last_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] rows_m1_ff, rows_m1_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             commit;
   logic             room;
   logic             is_new;
   logic             full;
   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] cnt_m1_sh;
   logic [CNT_W+CELL_BITS-1:0] cnt_ext;
   logic [CNT_W+CELL_BITS-1:0] cnt_sh;
   logic [CELL_BITS-1:0] wr_cell;
   logic [ROW_W-1:0]     wr_row;
   logic [IDX_W-1:0]     idx_sel;
   logic [UIDX_W+IDX_W-1:0] idx_wide;

   // cell chain
   tok_type          tok  [NUM_CELLS+1];
   logic [ROW_W-1:0] trow [NUM_CELLS+1];
   logic [IDX_W-1:0] tidx [NUM_CELLS+1];

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // row count for this probe: ceil(count / NUM_CELLS), at least one
   assign cnt_m1    = (count_ff == '0) ? '0 : count_ff - CNT_W'(1);
   assign cnt_m1_sh = cnt_m1 >> CELL_BITS;

   // store slot for a new entry
   assign cnt_ext = (CNT_W + CELL_BITS)'(count_ff);
   assign cnt_sh  = cnt_ext >> CELL_BITS;
   assign wr_cell = cnt_ext[CELL_BITS-1:0];
   assign wr_row  = cnt_sh[ROW_W-1:0];

   assign room   = (count_ff < CNT_W'(TABLE_DEPTH));
   assign is_new = !found_ff && room;
   assign full   = !found_ff && !room;

   assign idx_sel  = found_ff ? hit_idx_ff : (is_new ? count_ff[IDX_W-1:0] : '0);
   assign idx_wide = (UIDX_W + IDX_W)'(idx_sel);

   // token feed into cell 0
   assign tok[0]  = {(state_ff == ST_SCAN), (row_ff == rows_m1_ff), 1'b0};
   assign trow[0] = row_ff;
   assign tidx[0] = '0;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      vdi_cell #(
         .CELL_ID (k),
         .ROW_W   (ROW_W),
         .IDX_W   (IDX_W),
         .CNT_W   (CNT_W),
         .KEY_W   (KEY_W),
         .SLICE   (SLICE)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_i    (tok[k]),
         .row_i    (trow[k]),
         .idx_i    (tidx[k]),
         .tok_o    (tok[k+1]),
         .row_o    (trow[k+1]),
         .idx_o    (tidx[k+1]),
         .key_i    (key_ff),
         .count_i  (count_ff),
         .wr_en_i  (commit && is_new && (wr_cell == CELL_BITS'(k))),
         .wr_row_i (wr_row),
         .wr_key_i (key_ff)
      );
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      row_in       = row_ff;
      rows_m1_in   = rows_m1_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      commit       = 1'b0;

      // a match can leave the chain at most once per probe
      if (tok[NUM_CELLS].valid && tok[NUM_CELLS].found) begin
         found_in   = 1'b1;
         hit_idx_in = tidx[NUM_CELLS];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in     = {req_data.coord_x[STORE_BITS-1:0],
                             req_data.coord_y[STORE_BITS-1:0],
                             req_data.coord_z[STORE_BITS-1:0]};
               last_in    = req_data.last_vertex;
               row_in     = '0;
               rows_m1_in = cnt_m1_sh[ROW_W-1:0];
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            row_in = row_ff + ROW_W'(1);
            if (row_ff == rows_m1_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tok[NUM_CELLS].valid && tok[NUM_CELLS].last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // finish only when the output stage is free
            if (!rsp_valid_ff || !rsp_stall) begin
               commit                   = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_data_in.unique_index = idx_wide[UIDX_W-1:0];
               rsp_data_in.is_new       = is_new;
               rsp_data_in.table_full   = full;
               count_in = last_ff ? '0 : count_ff + CNT_W'(is_new);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      last_ff     <= last_in;
      row_ff      <= row_in;
      rows_m1_ff  <= rows_m1_in;
      found_ff    <= found_in;
      hit_idx_ff  <= hit_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vdi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vdi_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire vdi_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire vdi_pkg::rsp_type rsp_data
);
   import vdi_pkg::*;

   // a stalled vertex holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("req changed while stalled");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // one vertex in flight: a transfer closes the input side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken while a probe is running");

   // a new result only comes out of a running probe
   a_rsp_from_probe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp appeared with no probe");

   // overflow: flagged alone and with index zero
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |->
         !rsp_data.is_new && (rsp_data.unique_index == '0))
      else $error("bad table-full result");

endmodule

bind vertex_dedup_indexer_core vdi_checker u_vdi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> bench/tb_vertex_dedup_indexer_core.sv
`timescale 1ns / 1ps

module tb_vertex_dedup_indexer_core;
   import vdi_pkg::*;

   localparam int TABLE_SLOTS = TABLE_DEPTH_DEF;
   // No transfer on either side for this long means the block is hung; the
   // limit covers the slowest probe and the receiver's worst stall pattern.
   localparam int HANG_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 120;

   localparam logic [31:0] C_ZERO = 32'h0000_0000;
   localparam logic [31:0] C_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] C_MIN  = 32'h8000_0000;
   localparam logic [31:0] C_MAX  = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_BURSTY
   } rx_mode_type;

   // One row of the directed table; pinned rows carry their own answer
   typedef struct packed {
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
      logic              last;
      logic              pinned;
      logic [UIDX_W-1:0] index;
      logic              fresh;
      logic              full;
   } dir_row_type;

   typedef struct packed {
      req_type req;
      bit      pinned;
      rsp_type answer;
   } feed_item_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Directed vertices. A new list starts after every last mark, so the
   // index sequence restarts at 0 there.
   dir_row_type directed_rows [23] = '{
      '{C_ZERO, C_ZERO, C_ZERO, 0, 1, 0, 1, 0},  // first after reset
      '{C_MAX,  C_MAX,  C_MAX,  0, 1, 1, 1, 0},
      '{C_MIN,  C_MIN,  C_MIN,  0, 1, 2, 1, 0},
      '{C_ZERO, C_ZERO, C_ZERO, 0, 1, 0, 0, 0},  // hit on entry 0
      '{C_ONES, C_ONES, C_ONES, 0, 1, 3, 1, 0},
      '{C_MIN,  C_MIN,  C_MIN,  0, 1, 2, 0, 0},
      '{C_ZERO, C_ZERO, 32'h1,  0, 0, 0, 0, 0},  // one coordinate off by one bit
      '{C_ZERO, 32'h1,  C_ZERO, 0, 0, 0, 0, 0},
      '{32'h1,  C_ZERO, C_ZERO, 0, 0, 0, 0, 0},
      '{32'h1,  C_ZERO, C_ZERO, 0, 0, 0, 0, 0},  // same as the one just stored
      '{C_MAX,  C_MAX,  C_MAX,  1, 1, 1, 0, 0},  // hit, then table clears
      '{C_MAX,  C_MAX,  C_MAX,  0, 1, 0, 1, 0},  // new again after clear
      '{C_MIN,  C_MIN,  C_MIN,  0, 1, 1, 1, 0},  // stale copy in slot 2 ignored
      '{C_MIN,  C_MIN,  C_MIN,  1, 0, 0, 0, 0},
      '{32'h5,  32'h5,  32'h5,  1, 1, 0, 1, 0},  // list of one vertex
      '{32'h5,  32'h5,  32'h5,  0, 1, 0, 1, 0},
      '{C_MIN,  C_MAX,  C_ZERO, 0, 0, 0, 0, 0},
      '{C_MAX,  C_MIN,  C_ZERO, 0, 0, 0, 0, 0},  // swapped coordinates
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 0, 0, 0, 0, 0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 0, 0, 0, 0, 0},
      '{C_MIN,  C_MAX,  C_ZERO, 0, 0, 0, 0, 0},
      '{C_ZERO, C_MIN,  C_MAX,  0, 0, 0, 0, 0},  // rotated coordinates
      '{C_MAX,  C_MIN,  32'h1,  1, 0, 0, 0, 0}
   };

   feed_item_type vertex_feed[$];
   logic [95:0]   list_verts[$];   // vertices queued so far in the current list

   // Shadow of the dedup table. Entries [0, live_count) are exactly the
   // valid ones, since a list only ever appends and clears as a whole.
   logic [95:0] stored_vertex [TABLE_SLOTS];
   int          live_count = 0;

   rsp_type     index_expect[$];
   bit          row_pinned = 1'b0;
   rsp_type     row_answer = '0;
   rsp_type     predicted;
   rsp_type     want;

   int          mismatch_count = 0;
   int          rsp_seen       = 0;
   int          idle_cycles    = 0;

   rx_mode_type stall_mode = RX_OPEN;
   int          stall_hold = 0;
   logic [15:0] stall_tick = '0;

   vertex_dedup_indexer_core #(
      .TABLE_DEPTH(TABLE_DEPTH_DEF),
      .COORD_BITS (COORD_BITS_DEF)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Coordinates are full width here, so the stored key is the raw pattern.
   function automatic rsp_type next_index(req_type v);
      logic [95:0] key;
      rsp_type     r;
      bit          hit;
      key = {v.coord_x, v.coord_y, v.coord_z};
      r   = '0;
      hit = 1'b0;
      for (int i = 0; i < live_count; i++) begin
         if (!hit && stored_vertex[i] == key) begin
            hit            = 1'b1;
            r.unique_index = UIDX_W'(i);
         end
      end
      if (!hit) begin
         if (live_count < TABLE_SLOTS) begin
            stored_vertex[live_count] = key;
            r.unique_index = UIDX_W'(live_count);
            r.is_new       = 1'b1;
            live_count++;
         end else begin
            r.table_full = 1'b1;
         end
      end
      if (v.last_vertex) begin
         live_count = 0;
      end
      return r;
   endfunction

   function automatic void add_vertex(logic [95:0] key, bit last);
      feed_item_type it;
      it.req    = {key, last};
      it.pinned = 1'b0;
      it.answer = '0;
      vertex_feed.insert(vertex_feed.size(), it);
      if (last) begin
         list_verts.delete();
      end else begin
         list_verts.insert(list_verts.size(), key);
      end
   endfunction

   function automatic logic [95:0] fresh_vertex();
      return {$urandom(), $urandom(), $urandom()};
   endfunction

   function automatic logic [95:0] old_vertex();
      return list_verts[$urandom_range(0, list_verts.size() - 1)];
   endfunction

   function automatic logic [31:0] tiny_coord();
      int s;
      s = int'($urandom_range(0, 6)) - 3;
      return s;
   endfunction

   function automatic logic [31:0] edge_coord();
      case ($urandom_range(0, 3))
         0: return C_ZERO;
         1: return C_ONES;
         2: return C_MIN;
         default: return C_MAX;
      endcase
   endfunction

   task automatic report_miss(string field, int expected_val, int actual_val);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("result %0d: %s expected %0d, got %0d",
                  rsp_seen, field, expected_val, actual_val);
      end
   endtask

   // Receiver: stall pattern changes to a randomly chosen mode whenever its hold count runs out
   always @(negedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      if (stall_hold == 0) begin
         stall_mode <= rx_mode_type'($urandom_range(0, 3));
         stall_hold <= $urandom_range(16, 160);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         RX_OPEN:  rsp_stall <= 1'b0;
         RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         RX_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
         default:  rsp_stall <= (stall_tick[3:0] < 4'd11);
      endcase
   end

   // Both channels are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = next_index(req_data);
            index_expect.insert(index_expect.size(),
                                row_pinned ? row_answer : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (index_expect.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result %0d: unexpected transfer, index %0d",
                           rsp_seen, rsp_data.unique_index);
               end
            end else begin
               want = index_expect.pop_front();
               if (rsp_data.unique_index !== want.unique_index) begin
                  report_miss("unique_index", int'(want.unique_index),
                              int'(rsp_data.unique_index));
               end
               if (rsp_data.is_new !== want.is_new) begin
                  report_miss("is_new", int'(want.is_new), int'(rsp_data.is_new));
               end
               if (rsp_data.table_full !== want.table_full) begin
                  report_miss("table_full", int'(want.table_full),
                              int'(rsp_data.table_full));
               end
            end
            rsp_seen++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= HANG_LIMIT) begin
            $display("vertex_dedup_indexer_core regression: fail");
            $finish;
         end
      end
   end

   initial begin : main_flow
      feed_item_type cur;
      int         gap;
      int         burst_left;
      int         stored;
      logic [95:0] key;

      foreach (directed_rows[i]) begin
         cur.req    = {directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                       directed_rows[i].last};
         cur.pinned = directed_rows[i].pinned;
         cur.answer = {directed_rows[i].index, directed_rows[i].fresh,
                       directed_rows[i].full};
         vertex_feed.insert(vertex_feed.size(), cur);
      end

      // One list that fills the table, mostly new vertices with some hits
      stored = 0;
      while (stored < TABLE_SLOTS) begin
         if (list_verts.size() > 0 && $urandom_range(0, 4) == 0) begin
            add_vertex(old_vertex(), 1'b0);
         end else begin
            add_vertex(fresh_vertex(), 1'b0);
            stored++;
         end
      end
      // Table full now: hit on the newest entry, a miss, a hit on entry 0
      add_vertex(list_verts[list_verts.size() - 1], 1'b0);
      add_vertex(fresh_vertex(), 1'b0);
      add_vertex(list_verts[0], 1'b0);
      repeat (60) begin
         if ($urandom_range(0, 2) == 0) begin
            add_vertex(fresh_vertex(), 1'b0);
         end else begin
            add_vertex(old_vertex(), 1'b0);
         end
      end
      add_vertex(fresh_vertex(), 1'b1);   // miss while full, closes the list

      // Short lists with plenty of hits and near misses
      for (int n = 0; n < 260; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: key = fresh_vertex();
            3, 4:    key = {tiny_coord(), tiny_coord(), tiny_coord()};
            5:       key = (list_verts.size() > 0) ? list_verts[list_verts.size() - 1]
                                                   : fresh_vertex();
            6, 7:    key = (list_verts.size() > 0) ? old_vertex() : fresh_vertex();
            8: begin
               key = (list_verts.size() > 0) ? old_vertex() : fresh_vertex();
               key[$urandom_range(0, 95)] ^= 1'b1;
            end
            default: key = {edge_coord(), edge_coord(), edge_coord()};
         endcase
         add_vertex(key, (n == 259) || ($urandom_range(0, 29) == 0));
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender: bursts of back-to-back transfers separated by random gaps
      burst_left = 0;
      while (vertex_feed.size() > 0) begin
         cur = vertex_feed.pop_front();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
         req_valid  <= 1'b1;
         req_data   <= cur.req;
         row_pinned  = cur.pinned;
         row_answer  = cur.answer;
         do @(posedge clock); while (req_stall);
         @(negedge clock);
      end
      req_valid <= 1'b0;

      while (index_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      mismatch_count += index_expect.size();
      if (mismatch_count == 0) begin
         $display("vertex_dedup_indexer_core regression: pass");
      end else begin
         $display("vertex_dedup_indexer_core regression: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/vdi_pkg.sv
hw/rtl/vdi_cell.sv
hw/rtl/vertex_dedup_indexer_core.sv
hw/rtl/vdi_checker.sv
bench/tb_vertex_dedup_indexer_core.sv
